/* src/tti_pkg.sv */
// tti_pkg: shared widths, status and command codes, microcode word layout and the
// control store of the thermistor table interpolator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tti_pkg;

   localparam int VAL_W  = 12;
   localparam int IDX_W  = 8;
   localparam int TEMP_W = 11;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 3;
   localparam int WIDE_W = 17;
   localparam int PC_W   = 4;

   localparam int DEF_LAST_ENTRY      = 160;
   localparam int DEF_STEPS_PER_ENTRY = 10;
   localparam int DEF_SEARCH_ROUNDS   = 5;
   localparam int DEF_ADC_FULL_SCALE  = 4096;

   localparam logic [TEMP_W-1:0] TEMP_MAX = 11'd2047;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_BELOW = 2'd1;
   localparam logic [STAT_W-1:0] ST_ABOVE = 2'd2;

   localparam logic CMD_WRITE   = 1'b0;
   localparam logic CMD_CONVERT = 1'b1;

   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type STEP_IDLE        = 4'd0;
   localparam pc_type STEP_INIT        = 4'd1;
   localparam pc_type STEP_CHK_BELOW   = 4'd2;
   localparam pc_type STEP_CHK_ABOVE   = 4'd3;
   localparam pc_type STEP_PROBE       = 4'd4;
   localparam pc_type STEP_NARROW      = 4'd5;
   localparam pc_type STEP_RD_LO       = 4'd6;
   localparam pc_type STEP_HIT_LO      = 4'd7;
   localparam pc_type STEP_HIT_HI      = 4'd8;
   localparam pc_type STEP_WALK_ADDR   = 4'd9;
   localparam pc_type STEP_WALK_TEST   = 4'd10;
   localparam pc_type STEP_DIV_SETUP   = 4'd11;
   localparam pc_type STEP_DIV_STEP    = 4'd12;
   localparam pc_type STEP_SCALE       = 4'd13;
   localparam pc_type STEP_EMIT        = 4'd14;

   typedef enum logic [2:0] {
      ADDR_NONE,
      ADDR_ZERO,
      ADDR_LAST,
      ADDR_PROBE,
      ADDR_LO,
      ADDR_HI,
      ADDR_M
   } addr_sel_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_IDLE,
      OP_INIT,
      OP_CHK_BELOW,
      OP_CHK_ABOVE,
      OP_PROBE,
      OP_NARROW,
      OP_HIT_LO,
      OP_HIT_HI,
      OP_WALK_BOUND,
      OP_WALK_TEST,
      OP_DIV_SETUP,
      OP_DIV_STEP,
      OP_SCALE,
      OP_EMIT
   } op_type;

   // next: pc+1, flag: branch on flag, nflag: branch on flag clear, wait: branch on flag else hold
   typedef enum logic [1:0] {
      COND_NEXT,
      COND_FLAG,
      COND_NFLAG,
      COND_WAIT
   } cond_type;

   typedef struct packed {
      addr_sel_type addr_sel;
      op_type       op;
      cond_type     cond;
      pc_type       target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input pc_type pc);
      unique case (pc)
         STEP_IDLE:      ucode_rom = '{ADDR_NONE,  OP_IDLE,       COND_WAIT,  STEP_INIT};
         STEP_INIT:      ucode_rom = '{ADDR_ZERO,  OP_INIT,       COND_NEXT,  STEP_IDLE};
         STEP_CHK_BELOW: ucode_rom = '{ADDR_LAST,  OP_CHK_BELOW,  COND_FLAG,  STEP_EMIT};
         STEP_CHK_ABOVE: ucode_rom = '{ADDR_NONE,  OP_CHK_ABOVE,  COND_FLAG,  STEP_EMIT};
         STEP_PROBE:     ucode_rom = '{ADDR_PROBE, OP_PROBE,      COND_NEXT,  STEP_IDLE};
         STEP_NARROW:    ucode_rom = '{ADDR_NONE,  OP_NARROW,     COND_FLAG,  STEP_PROBE};
         STEP_RD_LO:     ucode_rom = '{ADDR_LO,    OP_NOP,        COND_NEXT,  STEP_IDLE};
         STEP_HIT_LO:    ucode_rom = '{ADDR_HI,    OP_HIT_LO,     COND_FLAG,  STEP_SCALE};
         STEP_HIT_HI:    ucode_rom = '{ADDR_NONE,  OP_HIT_HI,     COND_FLAG,  STEP_SCALE};
         STEP_WALK_ADDR: ucode_rom = '{ADDR_M,     OP_WALK_BOUND, COND_FLAG,  STEP_SCALE};
         STEP_WALK_TEST: ucode_rom = '{ADDR_NONE,  OP_WALK_TEST,  COND_NFLAG, STEP_WALK_ADDR};
         STEP_DIV_SETUP: ucode_rom = '{ADDR_NONE,  OP_DIV_SETUP,  COND_NFLAG, STEP_SCALE};
         STEP_DIV_STEP:  ucode_rom = '{ADDR_NONE,  OP_DIV_STEP,   COND_FLAG,  STEP_DIV_STEP};
         STEP_SCALE:     ucode_rom = '{ADDR_NONE,  OP_SCALE,      COND_NEXT,  STEP_IDLE};
         STEP_EMIT:      ucode_rom = '{ADDR_NONE,  OP_EMIT,       COND_WAIT,  STEP_IDLE};
         default:        ucode_rom = '{ADDR_NONE,  OP_NOP,        COND_NFLAG, STEP_IDLE};
      endcase
   endfunction

endpackage

`default_nettype wire

/* src/tti_ram.sv */
// tti_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tti_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 161
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/tti_seq.sv */
// tti_seq: microcode sequencer, step counter and control store lookup
// depends on tti_pkg
`timescale 1ns / 1ps
`default_nettype none

module tti_seq (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           flag,
   output tti_pkg::ucode_type  ctrl
);

   tti_pkg::pc_type pc_ff;
   tti_pkg::pc_type pc_in;
   tti_pkg::pc_type pc_inc;

   assign ctrl   = tti_pkg::ucode_rom(pc_ff);
   assign pc_inc = pc_ff + tti_pkg::pc_type'(1);

   always_comb begin
      unique case (ctrl.cond)
         tti_pkg::COND_NEXT:  pc_in = pc_inc;
         tti_pkg::COND_FLAG:  pc_in = flag ? ctrl.target : pc_inc;
         tti_pkg::COND_NFLAG: pc_in = flag ? pc_inc : ctrl.target;
         tti_pkg::COND_WAIT:  pc_in = flag ? ctrl.target : pc_ff;
         default:             pc_in = tti_pkg::STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= tti_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

/* src/tti_dp.sv */
// tti_dp: datapath of the interpolator: code table, search bracket, walk,
// shift-subtract divider, scaling and the result register
// depends on tti_pkg and tti_ram
`timescale 1ns / 1ps
`default_nettype none

module tti_dp #(
   parameter int LAST_ENTRY      = tti_pkg::DEF_LAST_ENTRY,
   parameter int STEPS_PER_ENTRY = tti_pkg::DEF_STEPS_PER_ENTRY,
   parameter int SEARCH_ROUNDS   = tti_pkg::DEF_SEARCH_ROUNDS,
   parameter int ADC_FULL_SCALE  = tti_pkg::DEF_ADC_FULL_SCALE
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tti_pkg::ucode_type            ctrl,
   output logic                               flag,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic                          command,
   input  wire logic [tti_pkg::IDX_W-1:0]     table_index,
   input  wire logic [tti_pkg::VAL_W-1:0]     table_value,
   input  wire logic [tti_pkg::VAL_W-1:0]     adc_sample,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [tti_pkg::TEMP_W-1:0]         temperature_tenths,
   output logic [tti_pkg::STAT_W-1:0]         range_status
);

   localparam int DEPTH  = LAST_ENTRY + 1;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int VW     = $clog2(ADC_FULL_SCALE + 1);
   localparam int CMP_W  = (VW > tti_pkg::VAL_W) ? VW : tti_pkg::VAL_W;
   localparam int QW     = (STEPS_PER_ENTRY > 1) ? $clog2(STEPS_PER_ENTRY) : 1;
   localparam int NUM_W  = tti_pkg::VAL_W + QW;
   localparam int TMP_W  = tti_pkg::IDX_W + QW + 1;
   localparam int IW     = tti_pkg::IDX_W;
   localparam int VALW   = tti_pkg::VAL_W;

   logic [CMP_W-1:0]           v_ff, v_in;
   logic [IW-1:0]              lo_ff, lo_in;
   logic [IW-1:0]              hi_ff, hi_in;
   logic [IW-1:0]              probe_ff, probe_in;
   logic [IW:0]                m_ff, m_in;
   logic [IW-1:0]              idx_ff, idx_in;
   logic [VALW-1:0]            lower_ff, lower_in;
   logic [VALW-1:0]            upper_ff, upper_in;
   logic [tti_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]           rem_ff, rem_in;
   logic [NUM_W-1:0]           dsh_ff, dsh_in;
   logic [QW-1:0]              q_ff, q_in;
   logic [tti_pkg::TEMP_W-1:0] temp_ff, temp_in;
   logic [tti_pkg::STAT_W-1:0] stat_ff, stat_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [tti_pkg::TEMP_W-1:0] rsp_temp_ff, rsp_temp_in;
   logic [tti_pkg::STAT_W-1:0] rsp_stat_ff, rsp_stat_in;

   logic [tti_pkg::WIDE_W-1:0] sample_w;
   logic [tti_pkg::WIDE_W-1:0] full_w;
   logic [tti_pkg::WIDE_W-1:0] inv_w;
   logic                       accept;
   logic                       wr_en;
   logic [ADDR_W-1:0]          rd_addr;
   logic [VALW-1:0]            rd_data;
   logic [CMP_W-1:0]           rd_ext;
   logic [IW-1:0]              probe_c;
   logic [IW:0]                m_dec;
   logic [VALW-1:0]            diff;
   logic [VALW-1:0]            den;
   logic [TMP_W-1:0]           scaled;
   logic                       cnt_nz;
   logic                       emit_free;

   tti_ram #(
      .WIDTH (VALW),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (table_index[ADDR_W-1:0]),
      .wr_data (table_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign in_ready  = (ctrl.op == tti_pkg::OP_IDLE);
   assign accept    = in_valid & in_ready;
   assign wr_en     = accept && (command == tti_pkg::CMD_WRITE)
                      && (table_index <= IW'(LAST_ENTRY));

   assign sample_w  = tti_pkg::WIDE_W'(adc_sample);
   assign full_w    = tti_pkg::WIDE_W'(ADC_FULL_SCALE);
   assign inv_w     = (sample_w > full_w) ? '0 : (full_w - sample_w);

   assign rd_ext    = CMP_W'(rd_data);
   assign probe_c   = (lo_ff >> 1) + (hi_ff >> 1);
   assign m_dec     = m_ff - (IW + 1)'(1);
   assign diff      = v_ff[VALW-1:0] - lower_ff;
   assign den       = upper_ff - lower_ff;
   assign scaled    = TMP_W'(idx_ff) * TMP_W'(STEPS_PER_ENTRY) + TMP_W'(q_ff);
   assign cnt_nz    = (cnt_ff != '0);
   assign emit_free = !rsp_valid_ff || out_ready;

   always_comb begin
      unique case (ctrl.addr_sel)
         tti_pkg::ADDR_ZERO:  rd_addr = '0;
         tti_pkg::ADDR_LAST:  rd_addr = ADDR_W'(LAST_ENTRY);
         tti_pkg::ADDR_PROBE: rd_addr = probe_c[ADDR_W-1:0];
         tti_pkg::ADDR_LO:    rd_addr = lo_ff[ADDR_W-1:0];
         tti_pkg::ADDR_HI:    rd_addr = hi_ff[ADDR_W-1:0];
         tti_pkg::ADDR_M:     rd_addr = m_ff[ADDR_W-1:0];
         default:             rd_addr = '0;
      endcase
   end

   always_comb begin
      unique case (ctrl.op)
         tti_pkg::OP_IDLE:       flag = in_valid && (command == tti_pkg::CMD_CONVERT);
         tti_pkg::OP_CHK_BELOW:  flag = v_ff < rd_ext;
         tti_pkg::OP_CHK_ABOVE:  flag = v_ff > rd_ext;
         tti_pkg::OP_NARROW:     flag = cnt_nz;
         tti_pkg::OP_HIT_LO:     flag = v_ff == rd_ext;
         tti_pkg::OP_HIT_HI:     flag = v_ff == rd_ext;
         tti_pkg::OP_WALK_BOUND: flag = m_ff > {1'b0, hi_ff};
         tti_pkg::OP_WALK_TEST:  flag = v_ff <= rd_ext;
         tti_pkg::OP_DIV_SETUP:  flag = (v_ff != CMP_W'(upper_ff)) && (v_ff > CMP_W'(lower_ff));
         tti_pkg::OP_DIV_STEP:   flag = cnt_nz;
         tti_pkg::OP_EMIT:       flag = emit_free;
         default:                flag = 1'b0;
      endcase
   end

   always_comb begin
      v_in        = v_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      probe_in    = probe_ff;
      m_in        = m_ff;
      idx_in      = idx_ff;
      lower_in    = lower_ff;
      upper_in    = upper_ff;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      dsh_in      = dsh_ff;
      q_in        = q_ff;
      temp_in     = temp_ff;
      stat_in     = stat_ff;
      rsp_temp_in = rsp_temp_ff;
      rsp_stat_in = rsp_stat_ff;
      rsp_valid_in = rsp_valid_ff & ~out_ready;
      unique case (ctrl.op)
         tti_pkg::OP_IDLE: begin
            if (accept) begin
               v_in = CMP_W'(inv_w);
            end
         end
         tti_pkg::OP_INIT: begin
            lo_in   = '0;
            hi_in   = IW'(LAST_ENTRY);
            cnt_in  = tti_pkg::CNT_W'(SEARCH_ROUNDS - 1);
            q_in    = '0;
            temp_in = '0;
            stat_in = tti_pkg::ST_OK;
         end
         tti_pkg::OP_CHK_BELOW: begin
            if (v_ff < rd_ext) begin
               stat_in = tti_pkg::ST_BELOW;
            end
         end
         tti_pkg::OP_CHK_ABOVE: begin
            if (v_ff > rd_ext) begin
               stat_in = tti_pkg::ST_ABOVE;
            end
         end
         tti_pkg::OP_PROBE: begin
            probe_in = probe_c;
         end
         tti_pkg::OP_NARROW: begin
            if (v_ff <= rd_ext) begin
               hi_in = probe_ff;
            end else begin
               lo_in = probe_ff;
            end
            cnt_in = cnt_ff - tti_pkg::CNT_W'(1);
         end
         tti_pkg::OP_HIT_LO: begin
            idx_in   = lo_ff;
            lower_in = rd_data;
            m_in     = {1'b0, lo_ff} + (IW + 1)'(1);
         end
         tti_pkg::OP_HIT_HI: begin
            idx_in = hi_ff;
         end
         tti_pkg::OP_WALK_BOUND: begin
            idx_in = hi_ff;
         end
         tti_pkg::OP_WALK_TEST: begin
            if (v_ff <= rd_ext) begin
               upper_in = rd_data;
               idx_in   = (v_ff == rd_ext) ? m_ff[IW-1:0] : m_dec[IW-1:0];
            end else begin
               lower_in = rd_data;
               m_in     = m_ff + (IW + 1)'(1);
            end
         end
         tti_pkg::OP_DIV_SETUP: begin
            rem_in = NUM_W'(diff) * NUM_W'(STEPS_PER_ENTRY);
            dsh_in = NUM_W'(den) << (QW - 1);
            cnt_in = tti_pkg::CNT_W'(QW - 1);
         end
         tti_pkg::OP_DIV_STEP: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               q_in   = QW'({q_ff, 1'b1});
            end else begin
               q_in   = QW'({q_ff, 1'b0});
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - tti_pkg::CNT_W'(1);
         end
         tti_pkg::OP_SCALE: begin
            temp_in = (scaled > TMP_W'(tti_pkg::TEMP_MAX)) ? tti_pkg::TEMP_MAX
                                                           : tti_pkg::TEMP_W'(scaled);
         end
         tti_pkg::OP_EMIT: begin
            if (emit_free) begin
               rsp_valid_in = 1'b1;
               rsp_temp_in  = temp_ff;
               rsp_stat_in  = stat_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      probe_ff    <= probe_in;
      m_ff        <= m_in;
      idx_ff      <= idx_in;
      lower_ff    <= lower_in;
      upper_ff    <= upper_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      q_ff        <= q_in;
      temp_ff     <= temp_in;
      stat_ff     <= stat_in;
      rsp_temp_ff <= rsp_temp_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign out_valid          = rsp_valid_ff;
   assign temperature_tenths = rsp_temp_ff;
   assign range_status       = rsp_stat_ff;

endmodule

`default_nettype wire

/* src/thermistor_table_interpolator.sv */
// thermistor_table_interpolator: top level, stream ports around the microcode
// sequencer and the datapath
// depends on tti_pkg, tti_seq, tti_dp (and through it tti_ram)
//
//  channel | direction | tdata                                      | tuser
//  req_    | in        | [7:0] table_index [19:8] table_value       | [0] command
//          |           | [31:20] adc_sample                         |
//  rsp_    | out       | [10:0] temperature_tenths [15:11] zero     | [1:0] range_status
//
//  a table write gives no transaction on rsp_
//  a convert below or above range goes from its range check straight to the result; in range
//  it runs the search rounds, the reads of the bracketing pair and a walk over the entries
//  through the single table read port, then the shift-subtract division and the scaling
//  the next transaction can be accepted in the same cycle as the result appears
//  reset clears the step counter and the result valid; the table holds no reset value
//  a result waiting on rsp_ stalls only the last step of the next convert
`timescale 1ns / 1ps
`default_nettype none

module thermistor_table_interpolator #(
   parameter int LAST_ENTRY      = tti_pkg::DEF_LAST_ENTRY,
   parameter int STEPS_PER_ENTRY = tti_pkg::DEF_STEPS_PER_ENTRY,
   parameter int SEARCH_ROUNDS   = tti_pkg::DEF_SEARCH_ROUNDS,
   parameter int ADC_FULL_SCALE  = tti_pkg::DEF_ADC_FULL_SCALE
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // table_index, table_value, adc_sample
   input  wire logic [0:0]  req_tuser,   // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // temperature_tenths, zero fill
   output logic [1:0]       rsp_tuser    // range_status
);

   tti_pkg::ucode_type               ctrl;
   logic                             flag;
   logic [tti_pkg::TEMP_W-1:0]       temperature_tenths;
   logic [tti_pkg::STAT_W-1:0]       range_status;

   tti_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flag  (flag),
      .ctrl  (ctrl)
   );

   tti_dp #(
      .LAST_ENTRY      (LAST_ENTRY),
      .STEPS_PER_ENTRY (STEPS_PER_ENTRY),
      .SEARCH_ROUNDS   (SEARCH_ROUNDS),
      .ADC_FULL_SCALE  (ADC_FULL_SCALE)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .flag               (flag),
      .in_valid           (req_tvalid),
      .in_ready           (req_tready),
      .command            (req_tuser[0]),
      .table_index        (req_tdata[7:0]),
      .table_value        (req_tdata[19:8]),
      .adc_sample         (req_tdata[31:20]),
      .out_valid          (rsp_tvalid),
      .out_ready          (rsp_tready),
      .temperature_tenths (temperature_tenths),
      .range_status       (range_status)
   );

   assign rsp_tdata = {5'd0, temperature_tenths};
   assign rsp_tuser = range_status;

endmodule

`default_nettype wire

/* src/tti_checker.sv */
// tti_checker: port-level assertions for thermistor_table_interpolator, with its bind
// depends on tti_pkg and the top level's port list
`timescale 1ns / 1ps
`default_nettype none

module tti_checker #(
   parameter int LAST_ENTRY      = tti_pkg::DEF_LAST_ENTRY,
   parameter int STEPS_PER_ENTRY = tti_pkg::DEF_STEPS_PER_ENTRY
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [0:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   localparam int SPAN     = LAST_ENTRY * STEPS_PER_ENTRY;
   localparam int TOP_TEMP = (SPAN > 2047) ? 2047 : SPAN;

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("rsp transaction changed while stalled");

   property p_flag_zero;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && (rsp_tuser != tti_pkg::ST_OK) |-> (rsp_tdata == 16'd0);
   endproperty
   a_flag_zero: assert property (p_flag_zero) else $error("out of range result not zero");

   property p_temp_top;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && (rsp_tuser == tti_pkg::ST_OK) |-> (rsp_tdata <= 16'(TOP_TEMP));
   endproperty
   a_temp_top: assert property (p_temp_top) else $error("temperature beyond table span");

   property p_convert_busy;
      @(posedge clock) disable iff (reset)
         req_tvalid && req_tready && (req_tuser[0] == tti_pkg::CMD_CONVERT) |=> !req_tready;
   endproperty
   a_convert_busy: assert property (p_convert_busy) else $error("ready right after convert");

endmodule

bind thermistor_table_interpolator tti_checker #(
   .LAST_ENTRY      (LAST_ENTRY),
   .STEPS_PER_ENTRY (STEPS_PER_ENTRY)
) u_tti_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

/* tb/sv/thermistor_reading_checker.sv */
// thermistor_reading_checker: watches the req_ and rsp_ streams of the thermistor table
// interpolator, predicts each conversion from its own copy of the code table and compares
// depends on tti_pkg
`timescale 1ns / 1ps

module thermistor_reading_checker
   import tti_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,   // table_index, table_value, adc_sample
   input  wire logic [0:0]  req_tuser,   // command
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,   // temperature_tenths, zero fill
   input  wire logic [1:0]  rsp_tuser,   // range_status
   output int               error_count,
   output int               readings_pending
);

   typedef struct packed {
      logic [TEMP_W-1:0] temperature_tenths;
      logic [STAT_W-1:0] range_status;
   } reading_type;

   logic [VAL_W-1:0] table_codes [0:DEF_LAST_ENTRY];
   reading_type      expected_readings [$];
   reading_type      oldest;

   function automatic int unsigned entry_code(input int unsigned idx);
      if (idx > DEF_LAST_ENTRY) return 0;
      return table_codes[idx];
   endfunction

   // halving search, then upward walk to the bracketing pair
   function automatic int unsigned locate_tenths(input int unsigned v);
      int unsigned lo;
      int unsigned hi;
      int unsigned probe;
      int unsigned upper;
      int unsigned lower;
      int unsigned frac;
      lo = 0;
      hi = DEF_LAST_ENTRY;
      for (int r = 0; r < DEF_SEARCH_ROUNDS; r++) begin
         probe = lo / 2 + hi / 2;
         if (v <= entry_code(probe)) hi = probe;
         else lo = probe;
      end
      if (v == entry_code(lo)) return lo * DEF_STEPS_PER_ENTRY;
      if (v == entry_code(hi)) return hi * DEF_STEPS_PER_ENTRY;
      for (int unsigned m = lo + 1; m <= hi; m++) begin
         upper = entry_code(m);
         if (v == upper) return m * DEF_STEPS_PER_ENTRY;
         if (v < upper) begin
            lower = entry_code(m - 1);
            frac = 0;
            if (v > lower) frac = ((v - lower) * DEF_STEPS_PER_ENTRY) / (upper - lower);
            return (m - 1) * DEF_STEPS_PER_ENTRY + frac;
         end
      end
      return hi * DEF_STEPS_PER_ENTRY;
   endfunction

   function automatic reading_type predict_reading(input logic [VAL_W-1:0] sample);
      int unsigned v;
      int unsigned tenths;
      reading_type r;
      v = (sample > DEF_ADC_FULL_SCALE) ? 0 : DEF_ADC_FULL_SCALE - sample;
      r.temperature_tenths = '0;
      if (v < entry_code(0)) begin
         r.range_status = ST_BELOW;
      end else if (v > entry_code(DEF_LAST_ENTRY)) begin
         r.range_status = ST_ABOVE;
      end else begin
         tenths = locate_tenths(v);
         if (tenths > TEMP_MAX) tenths = TEMP_MAX;
         r.temperature_tenths = TEMP_W'(tenths);
         r.range_status = ST_OK;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_readings.delete();
         readings_pending <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == CMD_CONVERT)
               expected_readings.push_back(predict_reading(req_tdata[31:20]));
            else if (req_tdata[7:0] <= DEF_LAST_ENTRY)
               table_codes[req_tdata[7:0]] = req_tdata[19:8];
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               report_mismatch("unexpected transaction, range_status", rsp_tuser, -1);
            end else begin
               oldest = expected_readings.pop_front();
               if (rsp_tdata[TEMP_W-1:0] !== oldest.temperature_tenths)
                  report_mismatch("temperature_tenths", rsp_tdata[TEMP_W-1:0],
                                  oldest.temperature_tenths);
               if (rsp_tuser !== oldest.range_status)
                  report_mismatch("range_status", rsp_tuser, oldest.range_status);
            end
         end
         readings_pending <= expected_readings.size();
      end
   end

endmodule

/* tb/sv/tb_thermistor_table_interpolator.sv */
// tb_thermistor_table_interpolator: loads code tables and sends conversions to the
// interpolator with random gaps and stalls, and gives the verdict
// depends on tti_pkg, thermistor_table_interpolator, thermistor_reading_checker
`timescale 1ns / 1ps

module tb_thermistor_table_interpolator;
   import tti_pkg::*;

   localparam int QUIET_LIMIT = 5000;

   typedef enum {
      TBL_LINEAR,
      TBL_FULL_SPAN,
      TBL_RISING,
      TBL_PLATEAU,
      TBL_NOISY
   } table_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // table_index, table_value, adc_sample
   logic [0:0]  req_tuser = '0;   // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // temperature_tenths, zero fill
   logic [1:0]  rsp_tuser;        // range_status

   int error_count;
   int readings_pending;
   int idle_pct = 31;
   int quiet_cycles = 0;

   logic [VAL_W-1:0] loaded_codes [0:DEF_LAST_ENTRY];

   always #5 clock = ~clock;

   thermistor_table_interpolator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   thermistor_reading_checker reading_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .error_count      (error_count),
      .readings_pending (readings_pending)
   );

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(0, 99) >= idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // called right after a rising edge; returns right after the accepting edge
   task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                            input logic [VAL_W-1:0] code, input logic [VAL_W-1:0] sample);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {sample, code, idx};
      req_tuser  <= cmd;
      if (cmd == CMD_WRITE && idx <= DEF_LAST_ENTRY) loaded_codes[idx] = code;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // v is the inverted value, 1 to full scale
   task automatic convert_code(input int unsigned v);
      send_item(CMD_CONVERT, IDX_W'($urandom_range(0, 255)), VAL_W'($urandom_range(0, 4095)),
                VAL_W'(DEF_ADC_FULL_SCALE - v));
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (readings_pending != 0) @(posedge clock);
   endtask

   task automatic load_table(input table_kind_type kind);
      int unsigned code;
      code = 0;
      for (int i = 0; i <= DEF_LAST_ENTRY; i++) begin
         case (kind)
            TBL_LINEAR:    code = 60 + i * 24;
            TBL_FULL_SPAN: code = (i * 4095) / DEF_LAST_ENTRY;
            TBL_RISING:    code = (i == 0) ? $urandom_range(0, 200) : code + $urandom_range(1, 24);
            TBL_PLATEAU:   code = (i == 0) ? $urandom_range(0, 1500) : code + $urandom_range(0, 30);
            TBL_NOISY:     code = $urandom_range(0, 4095);
         endcase
         if (code > 4095) code = 4095;
         send_item(CMD_WRITE, IDX_W'(i), VAL_W'(code), VAL_W'($urandom_range(0, 4095)));
      end
   endtask

   task automatic random_phase(input int count);
      int unsigned v;
      int unsigned lo_code;
      int unsigned hi_code;
      int unsigned pick;
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] code;
      for (int n = 0; n < count; n++) begin
         lo_code = loaded_codes[0];
         hi_code = loaded_codes[DEF_LAST_ENTRY];
         if (lo_code > hi_code) begin
            lo_code = loaded_codes[DEF_LAST_ENTRY];
            hi_code = loaded_codes[0];
         end
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            idx = ($urandom_range(0, 99) < 85) ? IDX_W'($urandom_range(0, DEF_LAST_ENTRY))
                                               : IDX_W'($urandom_range(DEF_LAST_ENTRY + 1, 255));
            if (idx <= DEF_LAST_ENTRY && $urandom_range(0, 1))
               code = loaded_codes[idx] + VAL_W'($urandom_range(0, 3));
            else
               code = VAL_W'($urandom_range(0, 4095));
            send_item(CMD_WRITE, idx, code, VAL_W'($urandom_range(0, 4095)));
         end else begin
            if (pick < 40) v = loaded_codes[$urandom_range(0, DEF_LAST_ENTRY)];
            else if (pick < 85) v = $urandom_range(lo_code, hi_code);
            else v = $urandom_range(1, DEF_ADC_FULL_SCALE);
            if (v == 0) v = 1;
            convert_code(v);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // edges of a plain rising table: first 60, last 3900, 24 per step
      load_table(TBL_LINEAR);
      convert_code(DEF_ADC_FULL_SCALE);
      convert_code(1);
      convert_code(59);
      convert_code(60);
      convert_code(61);
      convert_code(1980);
      convert_code(1986);
      convert_code(3899);
      convert_code(3900);
      convert_code(3901);
      // writes past the last entry are dropped
      send_item(CMD_WRITE, 8'd161, 12'hfff, 12'h000);
      send_item(CMD_WRITE, 8'd255, 12'h000, 12'hfff);
      convert_code(3900);
      // table not rising, then a flat pair
      send_item(CMD_WRITE, 8'd80, 12'hfff, 12'h555);
      convert_code(1986);
      convert_code(2004);
      send_item(CMD_WRITE, 8'd80, 12'd1980, 12'haaa);
      send_item(CMD_WRITE, 8'd81, 12'd1980, 12'h000);
      convert_code(1980);
      convert_code(1990);
      drain();

      load_table(TBL_FULL_SPAN);
      convert_code(1);
      convert_code(4095);
      convert_code(DEF_ADC_FULL_SCALE);
      drain();

      idle_pct = 0;
      load_table(TBL_RISING);
      random_phase(180);
      drain();
      idle_pct = 31;
      load_table(TBL_NOISY);
      random_phase(180);
      drain();
      load_table(TBL_PLATEAU);
      random_phase(180);
      drain();
      load_table(TBL_RISING);
      random_phase(180);
      drain();
      load_table(TBL_FULL_SPAN);
      random_phase(180);
      drain();

      repeat (64) @(posedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
